// ----- rtl/scsr_pkg.sv -----
package scsr_pkg;

  localparam int unsigned FIFO_DEPTH = 4;

  localparam int unsigned SPEED_W = 11;
  localparam int unsigned IVAL_W  = 8;
  localparam int unsigned CFG_IDX_W = 3;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_TH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_IV   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_IV = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_IV  = 3'd5;

  localparam logic [SPEED_W-1:0] RST_LONG_TH   = 11'd1840;
  localparam logic [SPEED_W-1:0] RST_MEDIUM_TH = 11'd1750;
  localparam logic [SPEED_W-1:0] RST_FLOOR     = 11'd1500;
  localparam logic [IVAL_W-1:0]  RST_LONG_IV   = 8'd60;
  localparam logic [IVAL_W-1:0]  RST_MEDIUM_IV = 8'd85;
  localparam logic [IVAL_W-1:0]  RST_SHORT_IV  = 8'd63;

  localparam logic [1:0] PROF_NONE   = 2'd0;
  localparam logic [1:0] PROF_LONG   = 2'd1;
  localparam logic [1:0] PROF_MEDIUM = 2'd2;
  localparam logic [1:0] PROF_SHORT  = 2'd3;

  localparam logic [7:0] LIMIT_LONG   = 8'd200;
  localparam logic [7:0] LIMIT_MEDIUM = 8'd227;
  localparam logic [7:0] LIMIT_SHORT  = 8'd187;

  // stop code 2000 split into its two bytes
  localparam logic [7:0] STOP_HI = 8'h07;
  localparam logic [7:0] STOP_LO = 8'hD0;

  typedef enum logic [1:0] {
    OP_BYTE,
    OP_TICK,
    OP_BYTE_LINK_DOWN,
    OP_TICK_LINK_DOWN
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [SPEED_W-1:0] long_th;
    logic [SPEED_W-1:0] medium_th;
    logic [SPEED_W-1:0] floor_v;
    logic [IVAL_W-1:0]  long_iv;
    logic [IVAL_W-1:0]  medium_iv;
    logic [IVAL_W-1:0]  short_iv;
  } cfg_t;

  function automatic logic [7:0] limit_of(logic [1:0] p);
    logic [7:0] l;
    case (p)
      PROF_LONG:   l = LIMIT_LONG;
      PROF_MEDIUM: l = LIMIT_MEDIUM;
      default:     l = LIMIT_SHORT;
    endcase
    return l;
  endfunction

endpackage

// ----- rtl/speed_command_soft_stop_ramp.sv -----
// Speed command decoder with soft-stop ramp.
// Input channel (in_valid/in_stall): one transaction per received byte or
// millisecond tick, each with the link status. Byte pairs form a command,
// low byte first; 0..255 sets the pulse width, 2000 or link loss starts a
// soft stop that steps the width down on ticks.
// Output channel (out_valid/out_stall): at most one result per input
// transaction, in input order.
// Config channel (cfg_valid/cfg_ready): always ready, index selects the
// register; write only while the block is idle.
// A result passes through the input register and the queue before execute
// writes the output register. Throughput: one transaction per cycle while
// the output is not stalled.
// Reset clears the queue, speed, pairing and ramp state; config registers
// return to their defaults.
// A stalled output holds its result; the execute stage then waits, the
// queue fills, and in_stall rises once the queue and input register are full.
module speed_command_soft_stop_ramp #(
  parameter int unsigned FIFO_DEPTH = scsr_pkg::FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_link_ok,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] out_pulse_us,
  output logic        out_ramping,
  output logic [1:0]  out_profile,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  scsr_pkg::cfg_t  cfg_r, cfg_nxt;
  logic            push, full, pop, empty;
  scsr_pkg::item_t push_item, pop_item;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        scsr_pkg::CFG_LONG_TH:   cfg_nxt.long_th   = cfg_data;
        scsr_pkg::CFG_MEDIUM_TH: cfg_nxt.medium_th = cfg_data;
        scsr_pkg::CFG_FLOOR:     cfg_nxt.floor_v   = cfg_data;
        scsr_pkg::CFG_LONG_IV:   cfg_nxt.long_iv   = cfg_data[7:0];
        scsr_pkg::CFG_MEDIUM_IV: cfg_nxt.medium_iv = cfg_data[7:0];
        scsr_pkg::CFG_SHORT_IV:  cfg_nxt.short_iv  = cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_th   <= scsr_pkg::RST_LONG_TH;
      cfg_r.medium_th <= scsr_pkg::RST_MEDIUM_TH;
      cfg_r.floor_v   <= scsr_pkg::RST_FLOOR;
      cfg_r.long_iv   <= scsr_pkg::RST_LONG_IV;
      cfg_r.medium_iv <= scsr_pkg::RST_MEDIUM_IV;
      cfg_r.short_iv  <= scsr_pkg::RST_SHORT_IV;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  scsr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .in_rx_byte (in_rx_byte),
    .in_link_ok (in_link_ok),
    .push       (push),
    .push_item  (push_item),
    .fifo_full  (full)
  );

  scsr_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (empty)
  );

  scsr_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .empty        (empty),
    .item         (pop_item),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_pulse_us (out_pulse_us),
    .out_ramping  (out_ramping),
    .out_profile  (out_profile)
  );

endmodule

// ----- rtl/scsr_front.sv -----
module scsr_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           in_command,
  input  logic [7:0]     in_rx_byte,
  input  logic           in_link_ok,
  output logic           push,
  output scsr_pkg::item_t push_item,
  input  logic           fifo_full
);

  logic            valid_r, valid_nxt;
  scsr_pkg::item_t item_r, item_nxt;
  logic            accept;

  assign in_stall  = valid_r && fifo_full;
  assign accept    = in_valid && !in_stall;
  assign push      = valid_r && !fifo_full;
  assign push_item = item_r;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (push) valid_nxt = 1'b0;
    if (accept) begin
      valid_nxt     = 1'b1;
      item_nxt.data = in_rx_byte;
      // a tick keeps its kind under link loss, a running ramp still counts it
      if (in_command) begin
        item_nxt.op = in_link_ok ? scsr_pkg::OP_TICK : scsr_pkg::OP_TICK_LINK_DOWN;
      end else begin
        item_nxt.op = in_link_ok ? scsr_pkg::OP_BYTE : scsr_pkg::OP_BYTE_LINK_DOWN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

endmodule

// ----- rtl/scsr_fifo.sv -----
module scsr_fifo #(
  parameter int unsigned DEPTH = scsr_pkg::FIFO_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  scsr_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output scsr_pkg::item_t pop_item,
  output logic            empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  scsr_pkg::item_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);
  assign pop_item = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    if (pop) rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_item;
  end

endmodule

// ----- rtl/scsr_back.sv -----
module scsr_back (
  input  logic            clk,
  input  logic            rst_n,
  input  scsr_pkg::cfg_t  cfg,
  input  logic            empty,
  input  scsr_pkg::item_t item,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [10:0]     out_pulse_us,
  output logic            out_ramping,
  output logic [1:0]      out_profile
);

  logic [10:0] map_tab [256];

  // command-to-pulse table, fixed at elaboration
  for (genvar g = 0; g < 256; g++) begin : g_map
    assign map_tab[g] = 11'(1000 + ((g - 50) * 1000) / 205);
  end

  logic [10:0] speed_r, speed_nxt;
  logic        held_r, held_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [1:0]  prof_r, prof_nxt;
  logic [7:0]  steps_r, steps_nxt;
  logic [7:0]  ms_r, ms_nxt;

  logic        ovalid_r, ovalid_nxt;
  logic [10:0] opulse_r, opulse_nxt;
  logic        oramp_r, oramp_nxt;
  logic [1:0]  oprof_r, oprof_nxt;

  logic              start, step_req, step_fail;
  logic [1:0]        step_prof, start_prof;
  logic [7:0]        steps_base, ival;
  logic signed [12:0] diff;
  logic [11:0]       next_v;

  assign pop          = !empty && (!ovalid_r || !out_stall);
  assign out_valid    = ovalid_r;
  assign out_pulse_us = opulse_r;
  assign out_ramping  = oramp_r;
  assign out_profile  = oprof_r;

  always_comb begin
    if (speed_r > cfg.long_th) start_prof = scsr_pkg::PROF_LONG;
    else if (speed_r > cfg.medium_th) start_prof = scsr_pkg::PROF_MEDIUM;
    else start_prof = scsr_pkg::PROF_SHORT;
  end

  always_comb begin
    speed_nxt = speed_r;
    held_nxt  = held_r;
    low_nxt   = low_r;
    prof_nxt  = prof_r;
    steps_nxt = steps_r;
    ms_nxt    = ms_r;
    ovalid_nxt = ovalid_r && out_stall;
    opulse_nxt = opulse_r;
    oramp_nxt  = oramp_r;
    oprof_nxt  = oprof_r;
    start      = 1'b0;
    step_req   = 1'b0;

    if (pop) begin
      if (prof_r != scsr_pkg::PROF_NONE) begin
        // bytes and link state are ignored while a ramp runs
        if (item.op inside {scsr_pkg::OP_TICK, scsr_pkg::OP_TICK_LINK_DOWN}) begin
          if (ms_r > 8'd1) begin
            ms_nxt = ms_r - 8'd1;
          end else begin
            ms_nxt = '0;
            if (steps_r >= scsr_pkg::limit_of(prof_r)) begin
              prof_nxt  = scsr_pkg::PROF_NONE;
              steps_nxt = '0;
            end else begin
              step_req = 1'b1;
            end
          end
        end
      end else begin
        unique case (item.op) inside
          scsr_pkg::OP_BYTE_LINK_DOWN, scsr_pkg::OP_TICK_LINK_DOWN: start = 1'b1;
          scsr_pkg::OP_BYTE: begin
            if (!held_r) begin
              low_nxt  = item.data;
              held_nxt = 1'b1;
            end else begin
              held_nxt = 1'b0;
              if (item.data == scsr_pkg::STOP_HI && low_r == scsr_pkg::STOP_LO) begin
                start = 1'b1;
              end else if (item.data == 8'd0) begin
                speed_nxt  = map_tab[low_r];
                ovalid_nxt = 1'b1;
                opulse_nxt = map_tab[low_r];
                oramp_nxt  = 1'b0;
                oprof_nxt  = scsr_pkg::PROF_NONE;
              end
            end
          end
          default: ;
        endcase
      end
    end

    step_prof  = start ? start_prof : prof_r;
    steps_base = start ? 8'd0 : steps_r;
    if (start) step_req = 1'b1;

    case (step_prof)
      scsr_pkg::PROF_LONG:   ival = cfg.long_iv;
      scsr_pkg::PROF_MEDIUM: ival = cfg.medium_iv;
      default:               ival = cfg.short_iv;
    endcase
    if (ival == 8'd0) ival = 8'd1;

    // (2*speed - 5 or 3) / 2, truncating toward zero
    diff = $signed({1'b0, speed_r, 1'b0})
         - ((step_prof == scsr_pkg::PROF_LONG) ? 13'sd5 : 13'sd3);
    next_v = (diff >= 13'sd0) ? diff[12:1] : 12'd0;
    step_fail = (diff < -13'sd1) || (next_v < {1'b0, cfg.floor_v});

    if (step_req) begin
      if (step_fail) begin
        prof_nxt  = scsr_pkg::PROF_NONE;
        steps_nxt = '0;
        ms_nxt    = '0;
      end else begin
        speed_nxt  = next_v[10:0];
        prof_nxt   = step_prof;
        steps_nxt  = steps_base + 8'd1;
        ms_nxt     = ival;
        ovalid_nxt = 1'b1;
        opulse_nxt = next_v[10:0];
        oramp_nxt  = 1'b1;
        oprof_nxt  = step_prof;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r  <= '0;
      held_r   <= 1'b0;
      low_r    <= '0;
      prof_r   <= scsr_pkg::PROF_NONE;
      steps_r  <= '0;
      ms_r     <= '0;
      ovalid_r <= 1'b0;
    end else begin
      speed_r  <= speed_nxt;
      held_r   <= held_nxt;
      low_r    <= low_nxt;
      prof_r   <= prof_nxt;
      steps_r  <= steps_nxt;
      ms_r     <= ms_nxt;
      ovalid_r <= ovalid_nxt;
    end
    opulse_r <= opulse_nxt;
    oramp_r  <= oramp_nxt;
    oprof_r  <= oprof_nxt;
  end

endmodule

// ----- tb/testbench.sv -----
module testbench;

  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_TICK  = 1'b1;
  localparam logic LINK_DOWN = 1'b0;
  localparam logic LINK_UP   = 1'b1;
  localparam logic [scsr_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
  localparam logic [15:0] STOP_CMD = {scsr_pkg::STOP_HI, scsr_pkg::STOP_LO};
  localparam int HOLD_CYCLES = 80;
  localparam int RANDOM_SETS = 3;

  typedef struct packed {
    logic [scsr_pkg::SPEED_W-1:0] pulse_us;
    logic                         ramping;
    logic [1:0]                   profile;
  } pulse_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_command;
  logic [7:0]  in_rx_byte;
  logic        in_link_ok;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [10:0] out_pulse_us;
  logic        out_ramping;
  logic [1:0]  out_profile;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [10:0] cfg_data;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  speed_command_soft_stop_ramp i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_rx_byte   (in_rx_byte),
    .in_link_ok   (in_link_ok),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_pulse_us (out_pulse_us),
    .out_ramping  (out_ramping),
    .out_profile  (out_profile),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // predicted block state
  scsr_pkg::cfg_t               cfg_now;
  logic [scsr_pkg::SPEED_W-1:0] cur_speed;
  logic                         pair_held;
  logic [7:0]                   pair_low;
  logic [1:0]                   ramp_prof;
  logic [7:0]                   ramp_steps;
  logic [7:0]                   ramp_ms_left;
  pulse_t                       pulse_q[$];

  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int ramp_results = 0;
  int cfg_writes = 0;

  // sender and receiver idling
  int burst_left = 0;
  bit steady = 1'b0;
  int stall_pct = 0;
  int stall_run = 0;
  bit stall_now = 1'b0;
  int hold_requests = 0;
  int holds_done = 0;
  int hold_left = 0;

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic logic [7:0] ramp_interval(logic [1:0] p);
    logic [7:0] iv;
    case (p)
      scsr_pkg::PROF_LONG:   iv = cfg_now.long_iv;
      scsr_pkg::PROF_MEDIUM: iv = cfg_now.medium_iv;
      default:               iv = cfg_now.short_iv;
    endcase
    return (iv == 8'd0) ? 8'd1 : iv;
  endfunction

  function automatic void ramp_down();
    int     half;
    int     nxt;
    pulse_t r;
    half = (ramp_prof == scsr_pkg::PROF_LONG) ? 5 : 3;
    nxt = (int'(cur_speed) * 2 - half) / 2;
    if (nxt < int'(cfg_now.floor_v)) begin
      ramp_prof = scsr_pkg::PROF_NONE;
      ramp_steps = 8'd0;
      ramp_ms_left = 8'd0;
      return;
    end
    cur_speed = nxt[10:0];
    ramp_steps = ramp_steps + 8'd1;
    ramp_ms_left = ramp_interval(ramp_prof);
    r.pulse_us = cur_speed;
    r.ramping = 1'b1;
    r.profile = ramp_prof;
    pulse_q.push_back(r);
  endfunction

  function automatic void start_soft_stop();
    if (cur_speed > cfg_now.long_th) begin
      ramp_prof = scsr_pkg::PROF_LONG;
    end else if (cur_speed > cfg_now.medium_th) begin
      ramp_prof = scsr_pkg::PROF_MEDIUM;
    end else begin
      ramp_prof = scsr_pkg::PROF_SHORT;
    end
    ramp_steps = 8'd0;
    ramp_down();
  endfunction

  function automatic void follow_item(logic cmd, logic [7:0] data, logic link);
    logic [15:0] value;
    logic [7:0]  cap;
    int          m;
    pulse_t      r;
    if (ramp_prof != scsr_pkg::PROF_NONE) begin
      if (cmd != CMD_TICK) return;
      if (ramp_ms_left > 8'd1) begin
        ramp_ms_left = ramp_ms_left - 8'd1;
        return;
      end
      ramp_ms_left = 8'd0;
      case (ramp_prof)
        scsr_pkg::PROF_LONG:   cap = scsr_pkg::LIMIT_LONG;
        scsr_pkg::PROF_MEDIUM: cap = scsr_pkg::LIMIT_MEDIUM;
        default:               cap = scsr_pkg::LIMIT_SHORT;
      endcase
      if (ramp_steps >= cap) begin
        ramp_prof = scsr_pkg::PROF_NONE;
        ramp_steps = 8'd0;
        return;
      end
      ramp_down();
      return;
    end
    if (link == LINK_DOWN) begin
      start_soft_stop();
      return;
    end
    if (cmd == CMD_TICK) return;
    if (!pair_held) begin
      pair_low = data;
      pair_held = 1'b1;
      return;
    end
    pair_held = 1'b0;
    value = {data, pair_low};
    if (value == STOP_CMD) begin
      start_soft_stop();
    end else if (value <= 16'd255) begin
      m = 1000 + ((int'(value) - 50) * 1000) / 205;
      cur_speed = m[10:0];
      r.pulse_us = cur_speed;
      r.ramping = 1'b0;
      r.profile = scsr_pkg::PROF_NONE;
      pulse_q.push_back(r);
    end
  endfunction

  task automatic send_item(logic cmd, logic [7:0] data, logic link);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      if (!steady && in_valid) begin
        gap = $urandom_range(1, 6);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_rx_byte <= data;
    in_link_ok <= link;
    do @(posedge clk); while (in_stall);
    follow_item(cmd, data, link);
    items_sent++;
  endtask

  task automatic send_command(logic [15:0] value);
    send_item(CMD_BYTE, value[7:0], LINK_UP);
    send_item(CMD_BYTE, value[15:8], LINK_UP);
  endtask

  // runs out any ramp and completes a half-received pair
  task automatic settle_state();
    while (ramp_prof != scsr_pkg::PROF_NONE) send_item(CMD_TICK, 8'h00, LINK_UP);
    if (pair_held) send_item(CMD_BYTE, 8'h00, LINK_UP);
  endtask

  task automatic pause_sender();
    if (in_valid) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    burst_left = 0;
  endtask

  task automatic write_reg(logic [scsr_pkg::CFG_IDX_W-1:0] idx, logic [10:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      scsr_pkg::CFG_LONG_TH:   cfg_now.long_th   = data;
      scsr_pkg::CFG_MEDIUM_TH: cfg_now.medium_th = data;
      scsr_pkg::CFG_FLOOR:     cfg_now.floor_v   = data;
      scsr_pkg::CFG_LONG_IV:   cfg_now.long_iv   = data[7:0];
      scsr_pkg::CFG_MEDIUM_IV: cfg_now.medium_iv = data[7:0];
      scsr_pkg::CFG_SHORT_IV:  cfg_now.short_iv  = data[7:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // registers change only once the block has drained
  task automatic apply_settings(int lt, int mt, int fl, int li, int mi, int si);
    pause_sender();
    while (pulse_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    write_reg(scsr_pkg::CFG_LONG_TH, lt[10:0]);
    write_reg(scsr_pkg::CFG_MEDIUM_TH, mt[10:0]);
    write_reg(scsr_pkg::CFG_FLOOR, fl[10:0]);
    write_reg(scsr_pkg::CFG_LONG_IV, li[10:0]);
    write_reg(scsr_pkg::CFG_MEDIUM_IV, mi[10:0]);
    write_reg(scsr_pkg::CFG_SHORT_IV, si[10:0]);
  endtask

  task automatic run_traffic(int n_items);
    int counted;
    int pick;
    int len;
    counted = 0;
    while (counted < n_items) begin
      if (ramp_prof != scsr_pkg::PROF_NONE) begin
        if ($urandom_range(0, 6) == 0) begin
          // dropped while the ramp runs
          send_item(CMD_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else begin
          len = $urandom_range(1, int'(ramp_ms_left) + 2);
          repeat (len) begin
            send_item(CMD_TICK, 8'($urandom_range(0, 255)), $urandom_range(0, 3) != 0);
            counted++;
          end
        end
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          send_command({8'h00, 8'($urandom_range(0, 255))});
          counted += 2;
        end else if (pick < 60) begin
          send_command(STOP_CMD);
          counted += 2;
        end else if (pick < 68) begin
          send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), LINK_DOWN);
          counted++;
        end else if (pick < 78) begin
          len = $urandom_range(1, 4);
          repeat (len) send_item(CMD_TICK, 8'($urandom_range(0, 255)), LINK_UP);
          counted += len;
        end else if (pick < 88) begin
          // lone byte shifts the pairing
          send_item(CMD_BYTE, 8'($urandom_range(0, 255)), LINK_UP);
          counted++;
        end else begin
          send_command({8'($urandom_range(1, 255)), 8'($urandom_range(0, 255))});
          counted += 2;
        end
      end
    end
  endtask

  task automatic test_speed_commands();
    send_item(CMD_TICK, 8'h00, LINK_UP);
    send_item(CMD_TICK, 8'hFF, LINK_UP);
    send_command(16'd0);
    send_command(16'd50);
    send_command(16'd255);
    send_command(16'd256);
    send_command(16'hFFFF);
    send_command(16'd200);
    send_command(16'd50);
  endtask

  // speed 1000 sits under the floor, so each stop ends at once
  task automatic test_stop_below_floor();
    send_item(CMD_BYTE, 8'hA5, LINK_DOWN);
    send_item(CMD_TICK, 8'h5A, LINK_DOWN);
    send_command(STOP_CMD);
  endtask

  task automatic test_ramp_entry();
    send_command(16'd255);
    send_command(STOP_CMD);
    send_item(CMD_BYTE, 8'h3C, LINK_UP);
    send_item(CMD_TICK, 8'h00, LINK_DOWN);
  endtask

  task automatic test_extremes_low();
    apply_settings(0, 0, 0, 0, 0, 0);
    write_reg(CFG_SPARE, 11'h7FF);
    stall_pct = 0;
    settle_state();
    // two ramps back to back run the speed down until a step would go negative
    send_command(16'd0);
    repeat (2) begin
      send_command(STOP_CMD);
      while (ramp_prof != scsr_pkg::PROF_NONE)
        send_item(CMD_TICK, 8'($urandom_range(0, 255)), LINK_UP);
    end
    run_traffic(80);
  endtask

  task automatic test_extremes_high();
    apply_settings(2047, 2047, 2047, 255, 255, 255);
    stall_pct = 60;
    run_traffic(80);
  endtask

  task automatic test_output_hold();
    settle_state();
    steady = 1'b1;
    hold_requests++;
    repeat (24) send_command({8'h00, 8'($urandom_range(0, 255))});
    steady = 1'b0;
  endtask

  task automatic test_random_settings();
    int lt;
    int mt;
    int fl;
    repeat (RANDOM_SETS) begin
      lt = $urandom_range(1600, 2047);
      mt = $urandom_range(1200, lt);
      fl = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(700, 1950);
      apply_settings(lt, mt, fl, $urandom_range(0, 5), $urandom_range(0, 5),
                     $urandom_range(0, 5));
      stall_pct = $urandom_range(0, 70);
      run_traffic(100);
    end
  endtask

  // receiver stall pattern, with an occasional long hold
  always @(negedge clk) begin
    if (holds_done < hold_requests) begin
      holds_done++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (stall_run == 0) begin
        stall_run = $urandom_range(1, 8);
        stall_now = ($urandom_range(0, 99) < stall_pct);
      end
      stall_run--;
      out_stall <= stall_now;
    end
  end

  always @(posedge clk) begin : check_results
    pulse_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pulse_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, pulse %0d", out_pulse_us));
      end else begin
        want = pulse_q.pop_front();
        if (out_pulse_us !== want.pulse_us)
          report_mismatch($sformatf("pulse_us %0d, expected %0d", out_pulse_us, want.pulse_us));
        if (out_ramping !== want.ramping)
          report_mismatch($sformatf("ramping %0b, expected %0b", out_ramping, want.ramping));
        if (out_profile !== want.profile)
          report_mismatch($sformatf("profile %0d, expected %0d", out_profile, want.profile));
        results_seen++;
        if (want.ramping) ramp_results++;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int w;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_BYTE;
    in_rx_byte = 8'h00;
    in_link_ok = LINK_UP;
    cfg_valid = 1'b0;
    cfg_index = scsr_pkg::CFG_LONG_TH;
    cfg_data = 11'd0;
    cfg_now.long_th = scsr_pkg::RST_LONG_TH;
    cfg_now.medium_th = scsr_pkg::RST_MEDIUM_TH;
    cfg_now.floor_v = scsr_pkg::RST_FLOOR;
    cfg_now.long_iv = scsr_pkg::RST_LONG_IV;
    cfg_now.medium_iv = scsr_pkg::RST_MEDIUM_IV;
    cfg_now.short_iv = scsr_pkg::RST_SHORT_IV;
    cur_speed = '0;
    pair_held = 1'b0;
    pair_low = 8'h00;
    ramp_prof = scsr_pkg::PROF_NONE;
    ramp_steps = 8'd0;
    ramp_ms_left = 8'd0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    stall_pct = 30;
    test_speed_commands();
    test_stop_below_floor();
    test_ramp_entry();
    run_traffic(100);
    test_extremes_low();
    test_extremes_high();
    test_output_hold();
    test_random_settings();

    pause_sender();
    for (w = 0; w < 200000 && pulse_q.size() != 0; w++) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d transactions in, %0d results out (%0d ramp steps), %0d register writes",
             items_sent, results_seen, ramp_results, cfg_writes);
    $display("settings: reset, all low, all high, %0d random sets, one %0d-cycle output hold",
             RANDOM_SETS, HOLD_CYCLES);
    if (mismatches == 0 && pulse_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, pulse_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/scsr_pkg.sv
rtl/scsr_front.sv
rtl/scsr_fifo.sv
rtl/scsr_back.sv
rtl/speed_command_soft_stop_ramp.sv
tb/testbench.sv
